/* src/dfr_pkg.sv */
// shared types and constants of the length-prefixed deframer
package dfr_pkg;

  localparam int unsigned HdrBytes = 10;
  localparam logic [31:0] HdrLen = 32'(HdrBytes);
  localparam logic [31:0] MaxFrameReset = 32'(1024 * 1024 * 4);

  // configuration space: one 32-bit register per word
  localparam int unsigned CfgAddrW = 3;
  localparam logic REG_MAX_FRAME_LEN = 1'b0;

  // depth of the queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic {
    ERR_SHORT = 1'b0,
    ERR_LONG  = 1'b1
  } err_code_t;

  typedef struct packed {
    logic [31:0] msg_length;
    logic [31:0] seq_number;
    logic [15:0] command_id;
  } hdr_t;

  // one classified beat from front to back
  typedef struct packed {
    kind_t       kind;
    err_code_t   error_code;
    logic [7:0]  payload_byte;
    logic        last;
    hdr_t        hdr;
  } q_entry_t;

endpackage

/* src/dfr_if.sv */
// valid/ready channel interfaces of the deframer

interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface dfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        error_code;
  logic [31:0] msg_length;
  logic [31:0] seq_number;
  logic [15:0] command_id;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output kind, output error_code, output msg_length,
                  output seq_number, output command_id, output payload_byte,
                  output last, input ready);
  modport sink (input valid, input kind, input error_code, input msg_length,
                input seq_number, input command_id, input payload_byte,
                input last, output ready);
endinterface

/* src/dfr_front.sv */
// front end: header assembly, length checks and payload counting
module dfr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          data_byte,
  input  logic                restart,
  input  logic [31:0]         max_frame_len,
  output logic                push,
  output dfr_pkg::q_entry_t   entry
);

  logic [3:0]  header_count_r, header_count_nxt;
  logic [31:0] length_r, length_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [31:0] payload_left_r, payload_left_nxt;
  logic        error_r, error_nxt;

  always_comb begin
    header_count_nxt = header_count_r;
    length_nxt       = length_r;
    seq_nxt          = seq_r;
    cmd_nxt          = cmd_r;
    payload_left_nxt = payload_left_r;
    error_nxt        = error_r;
    push             = 1'b0;
    entry            = '0;
    entry.kind       = dfr_pkg::KIND_HEADER;
    entry.error_code = dfr_pkg::ERR_SHORT;
    if (acc) begin
      if (restart) begin
        header_count_nxt = '0;
        length_nxt       = '0;
        seq_nxt          = '0;
        cmd_nxt          = '0;
        payload_left_nxt = '0;
        error_nxt        = 1'b0;
      end else if (!error_r) begin
        if (payload_left_r != '0) begin
          payload_left_nxt   = payload_left_r - 32'd1;
          push               = 1'b1;
          entry.kind         = dfr_pkg::KIND_PAYLOAD;
          entry.payload_byte = data_byte;
          entry.last         = (payload_left_r == 32'd1);
        end else begin
          if (header_count_r < 4'd4) begin
            length_nxt = {length_r[23:0], data_byte};
          end else if (header_count_r < 4'd8) begin
            seq_nxt = {seq_r[23:0], data_byte};
          end else begin
            cmd_nxt = {cmd_r[7:0], data_byte};
          end
          header_count_nxt = header_count_r + 4'd1;
          if (header_count_r == 4'(dfr_pkg::HdrBytes - 1)) begin
            // header complete: length bytes are already in length_r
            header_count_nxt          = '0;
            push                      = 1'b1;
            entry.hdr.msg_length      = length_r;
            entry.hdr.seq_number      = seq_r;
            entry.hdr.command_id      = cmd_nxt;
            if (length_r < dfr_pkg::HdrLen) begin
              error_nxt        = 1'b1;
              entry.kind       = dfr_pkg::KIND_ERROR;
              entry.error_code = dfr_pkg::ERR_SHORT;
            end else if (length_r > max_frame_len) begin
              error_nxt        = 1'b1;
              entry.kind       = dfr_pkg::KIND_ERROR;
              entry.error_code = dfr_pkg::ERR_LONG;
            end else begin
              payload_left_nxt = length_r - dfr_pkg::HdrLen;
              entry.kind       = dfr_pkg::KIND_HEADER;
              entry.last       = (length_r == dfr_pkg::HdrLen);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r <= '0;
      length_r       <= '0;
      seq_r          <= '0;
      cmd_r          <= '0;
      payload_left_r <= '0;
      error_r        <= 1'b0;
    end else begin
      header_count_r <= header_count_nxt;
      length_r       <= length_nxt;
      seq_r          <= seq_nxt;
      cmd_r          <= cmd_nxt;
      payload_left_r <= payload_left_nxt;
      error_r        <= error_nxt;
    end
  end

  a_payload_no_header: assert property (@(posedge clk) disable iff (!rst_n)
    (payload_left_r != '0) |-> (header_count_r == '0))
    else $error("payload phase with partial header");

  a_error_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    error_r |-> (payload_left_r == '0))
    else $error("sticky error with payload pending");

endmodule

/* src/dfr_queue.sv */
// short queue between front and back
module dfr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dfr_pkg::q_entry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output dfr_pkg::q_entry_t head
);

  dfr_pkg::q_entry_t                 slot_r [dfr_pkg::QDepth];
  logic [dfr_pkg::QPtrW-1:0]         wr_ptr_r, rd_ptr_r;
  logic [dfr_pkg::QCntW-1:0]         count_r;

  assign full      = (count_r == dfr_pkg::QCntW'(dfr_pkg::QDepth));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

/* src/dfr_back.sv */
// back end: header tracking and registered result stage
module dfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  dfr_pkg::q_entry_t q_head,
  output logic              pop,
  dfr_out_if.source         out_ch
);

  logic                valid_r;
  dfr_pkg::kind_t      kind_r;
  dfr_pkg::err_code_t  code_r;
  logic [7:0]          byte_r;
  logic                last_r;
  dfr_pkg::hdr_t       hdr_r;

  assign pop = q_not_empty && (!valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload beats reuse the header of the message in flight
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= q_head.kind;
      code_r <= q_head.error_code;
      byte_r <= q_head.payload_byte;
      last_r <= q_head.last;
      if (q_head.kind != dfr_pkg::KIND_PAYLOAD) begin
        hdr_r <= q_head.hdr;
      end
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.error_code   = code_r;
  assign out_ch.payload_byte = byte_r;
  assign out_ch.last         = last_r;
  assign out_ch.msg_length   = hdr_r.msg_length;
  assign out_ch.seq_number   = hdr_r.seq_number;
  assign out_ch.command_id   = hdr_r.command_id;

  a_drop_only_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(valid_r) |-> $past(out_ch.ready))
    else $error("result dropped without being taken");

endmodule

/* src/length_prefixed_deframer_core.sv */
// top level of the length-prefixed message deframer
//
// usage: in_ch carries one stream byte per beat, or a restart beat that
// clears the parser and the sticky error for a new connection. out_ch
// carries one result beat per completed header, per payload byte, or per
// framing error; msg_length, seq_number and command_id always show the
// header of the message in flight. max_frame_len sits at byte address 0
// of the cfg_ apb port; the user must write it only while the block is
// idle, which the block does not enforce. one beat per cycle is taken and
// delivered in steady state while out_ch.ready stays high; the front
// parser does one counter step and one 32-bit compare per byte, the back
// stage is a single output register. reset: parser state clears,
// max_frame_len returns to 4 MiB, out_ch goes empty. when the receiver
// stalls, the output register holds and the two-entry queue absorbs up to
// two more results before in_ch.ready drops.
module length_prefixed_deframer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  dfr_in_if.sink                        in_ch,
  dfr_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dfr_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic              in_acc;
  logic              push;
  dfr_pkg::q_entry_t push_entry;
  logic              q_full;
  logic              q_not_empty;
  dfr_pkg::q_entry_t q_head;
  logic              pop;
  logic [31:0]       max_frame_len_r;
  logic              cfg_hit;

  // config register: word index is paddr[2], only index 0 exists
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == dfr_pkg::REG_MAX_FRAME_LEN);
  assign cfg_prdata = cfg_hit ? max_frame_len_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_len_r <= dfr_pkg::MaxFrameReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      max_frame_len_r <= cfg_pwdata;
    end
  end

  // take a byte whenever the queue has room
  assign in_ch.ready = !q_full;
  assign in_acc      = in_ch.valid && !q_full;

  dfr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (in_acc),
    .data_byte     (in_ch.data_byte),
    .restart       (in_ch.restart),
    .max_frame_len (max_frame_len_r),
    .push          (push),
    .entry         (push_entry)
  );

  dfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  dfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

/* dv/tb_length_prefixed_deframer_core.sv */
// testbench of the length-prefixed deframer core: directed and random byte streams, scoreboarded
module tb_length_prefixed_deframer_core;

  // cycles with no beat on any port before the run is called hung
  localparam int unsigned StallLimit = 5000;
  // settle time after the last expected result, covers the output register and the queue
  localparam int unsigned DrainCycles = 8;
  // longest payload run sent before a message is cut short by a restart
  localparam int unsigned PayloadCap = 48;
  // register index times four gives the byte address
  localparam logic [dfr_pkg::CfgAddrW-1:0] AddrMaxFrameLen =
    {dfr_pkg::REG_MAX_FRAME_LEN, 2'b00};
  // next word up, no register behind it
  localparam logic [dfr_pkg::CfgAddrW-1:0] AddrUnused = {~dfr_pkg::REG_MAX_FRAME_LEN, 2'b00};
  localparam int unsigned MaxPrinted = 40;

  // one result as the deframer should deliver it
  typedef struct {
    dfr_pkg::kind_t     kind;
    dfr_pkg::err_code_t code;
    logic [31:0]        msg_len;
    logic [31:0]        seq;
    logic [15:0]        cmd;
    logic [7:0]         pbyte;
    logic               last;
  } deframe_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [dfr_pkg::CfgAddrW-1:0] cfg_paddr;
  logic [31:0]                  cfg_pwdata;
  logic [31:0]                  cfg_prdata;
  logic                         cfg_pready;

  dfr_in_if  in_ch ();
  dfr_out_if out_ch ();

  length_prefixed_deframer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // parser mirror: header being assembled, payload still owed, sticky error
  logic [3:0]  hdr_count;
  logic [31:0] len_acc;
  logic [31:0] seq_acc;
  logic [15:0] cmd_acc;
  logic [31:0] payload_left;
  logic        error_sticky;
  logic [31:0] max_frame;

  deframe_result_t pending_results[$];

  int unsigned src_idle_pct = 9;
  int unsigned sink_idle_pct = 82;
  int unsigned mismatches = 0;
  int unsigned bytes_fed = 0;
  int unsigned restarts = 0;
  int unsigned headers_seen = 0;
  int unsigned payloads_seen = 0;
  int unsigned short_errs = 0;
  int unsigned long_errs = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void clear_parser();
    hdr_count    = '0;
    len_acc      = '0;
    seq_acc      = '0;
    cmd_acc      = '0;
    payload_left = '0;
    error_sticky = 1'b0;
  endfunction

  // every result carries the header of the message in flight
  function automatic deframe_result_t shape_result(dfr_pkg::kind_t k, dfr_pkg::err_code_t c,
                                                   logic [7:0] pb, logic lst);
    deframe_result_t r;
    r.kind    = k;
    r.code    = c;
    r.msg_len = len_acc;
    r.seq     = seq_acc;
    r.cmd     = cmd_acc;
    r.pbyte   = pb;
    r.last    = lst;
    return r;
  endfunction

  // append one prediction behind the ones already waiting
  function automatic void queue_result(deframe_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // advance the parser mirror by one accepted beat, queue the result it causes
  function automatic void deframe_byte(logic [7:0] b, logic rs);
    if (rs) begin
      clear_parser();
    end else if (error_sticky) begin
      // sticky error: byte dropped, nothing out
    end else if (payload_left != 0) begin
      payload_left = payload_left - 32'd1;
      queue_result(shape_result(dfr_pkg::KIND_PAYLOAD, dfr_pkg::ERR_SHORT, b,
                                payload_left == 0));
    end else begin
      // header bytes arrive big-endian: length, sequence, command
      if (hdr_count < 4) len_acc = {len_acc[23:0], b};
      else if (hdr_count < 8) seq_acc = {seq_acc[23:0], b};
      else cmd_acc = {cmd_acc[7:0], b};
      hdr_count = hdr_count + 4'd1;
      if (hdr_count == dfr_pkg::HdrBytes) begin
        hdr_count = '0;
        // the short check wins over the maximum check, even when max is below ten
        if (len_acc < dfr_pkg::HdrLen) begin
          error_sticky = 1'b1;
          queue_result(shape_result(dfr_pkg::KIND_ERROR, dfr_pkg::ERR_SHORT, 8'h00, 1'b0));
        end else if (len_acc > max_frame) begin
          error_sticky = 1'b1;
          queue_result(shape_result(dfr_pkg::KIND_ERROR, dfr_pkg::ERR_LONG, 8'h00, 1'b0));
        end else begin
          payload_left = len_acc - dfr_pkg::HdrLen;
          queue_result(shape_result(dfr_pkg::KIND_HEADER, dfr_pkg::ERR_SHORT, 8'h00,
                                    payload_left == 0));
        end
      end
    end
  endfunction

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.restart   = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    max_frame       = dfr_pkg::MaxFrameReset;
    clear_parser();
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MaxPrinted)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // result beats are taken at the rising edge and compared with the oldest prediction
  always @(posedge clk) begin : result_check
    deframe_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(out_ch.kind), 32'h0);
      end else begin
        e = pending_results.pop_front();
        if (out_ch.kind != e.kind)
          report_mismatch("kind", 32'(out_ch.kind), 32'(e.kind));
        if (out_ch.error_code != e.code)
          report_mismatch("error_code", 32'(out_ch.error_code), 32'(e.code));
        if (out_ch.msg_length != e.msg_len)
          report_mismatch("msg_length", out_ch.msg_length, e.msg_len);
        if (out_ch.seq_number != e.seq) report_mismatch("seq_number", out_ch.seq_number, e.seq);
        if (out_ch.command_id != e.cmd)
          report_mismatch("command_id", 32'(out_ch.command_id), 32'(e.cmd));
        if (out_ch.payload_byte != e.pbyte)
          report_mismatch("payload_byte", 32'(out_ch.payload_byte), 32'(e.pbyte));
        if (out_ch.last != e.last) report_mismatch("last", 32'(out_ch.last), 32'(e.last));
        case (e.kind)
          dfr_pkg::KIND_HEADER:  headers_seen++;
          dfr_pkg::KIND_PAYLOAD: payloads_seen++;
          default: begin
            if (e.code == dfr_pkg::ERR_SHORT) short_errs++;
            else long_errs++;
          end
        endcase
      end
    end
  end

  // receiver back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // ---------------------------------------------------------------- stimulus

  // one beat on in_ch; valid stays high afterwards so back-to-back beats need no gap
  task automatic send_beat(input logic [7:0] b, input logic rs);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.restart   <= rs;
    do @(posedge clk); while (!in_ch.ready);
    // bytes dropped under a sticky error are not counted as traffic
    if (rs) restarts++;
    else if (!error_sticky) bytes_fed++;
    deframe_byte(b, rs);
  endtask

  task automatic send_restart();
    send_beat(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_header(input logic [31:0] len, input logic [31:0] seq,
                             input logic [15:0] cmd);
    logic [79:0] hdr;
    hdr = {len, seq, cmd};
    for (int i = 0; i < dfr_pkg::HdrBytes; i++) send_beat(hdr[79 - 8*i -: 8], 1'b0);
  endtask

  task automatic send_payload(input int unsigned n);
    repeat (n) send_beat(8'($urandom_range(255)), 1'b0);
  endtask

  // drop valid and let every outstanding result and any header-only beat drain
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // apb: setup cycle, then access cycle; the write lands at the access edge
  task automatic apb_write(input logic [dfr_pkg::CfgAddrW-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [dfr_pkg::CfgAddrW-1:0] addr,
                                input logic [31:0] want);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata != want) report_mismatch("max_frame_len readback", cfg_prdata, want);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_max_frame(input logic [31:0] v);
    wait_idle();
    apb_write(AddrMaxFrameLen, v);
    max_frame = v;
    apb_read_check(AddrMaxFrameLen, v);
  endtask

  // ---------------------------------------------------------------- tests

  // header-only messages with extreme fields, short payloads with extreme bytes
  task automatic test_header_fields();
    apb_read_check(AddrMaxFrameLen, dfr_pkg::MaxFrameReset);
    send_header(dfr_pkg::HdrLen, 32'hFFFF_FFFF, 16'hFFFF);
    send_header(dfr_pkg::HdrLen, 32'h0, 16'h0);
    send_header(dfr_pkg::HdrLen + 32'd1, 32'h1234_5678, 16'hA5C3);
    send_beat(8'hFF, 1'b0);
    send_header(dfr_pkg::HdrLen + 32'd2, 32'h8000_0001, 16'h8001);
    send_beat(8'h00, 1'b0);
    send_beat(8'h5A, 1'b0);
  endtask

  // short and over-length headers at the default maximum, sticky drop until restart
  task automatic test_length_errors();
    send_header(32'h0, 32'hCAFE_0001, 16'h0102);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_restart();
    send_header(dfr_pkg::HdrLen - 32'd1, 32'h0000_0002, 16'h7FFF);
    send_restart();
    send_header(dfr_pkg::MaxFrameReset + 32'd1, 32'h0000_0003, 16'h0003);
    send_restart();
    // largest legal message: header, a few payload bytes, then cut short
    send_header(dfr_pkg::MaxFrameReset, 32'h0000_0004, 16'h0004);
    send_payload(3);
    send_restart();
    send_header(32'hFFFF_FFFF, 32'h0000_0005, 16'h0005);
    send_restart();
  endtask

  // extreme maximum settings, a maximum below the header size, writes to no register
  task automatic test_max_extremes();
    set_max_frame(dfr_pkg::HdrLen);
    send_header(dfr_pkg::HdrLen, 32'h0000_0010, 16'h0010);
    send_header(dfr_pkg::HdrLen + 32'd1, 32'h0000_0011, 16'h0011);
    send_restart();
    set_max_frame(32'hFFFF_FFFF);
    send_header(32'hFFFF_FFFF, 32'h0000_0012, 16'h0012);
    send_payload(2);
    send_restart();
    // below ten every header fails, short or long by its own length
    set_max_frame(32'd5);
    send_header(32'd7, 32'h0000_0013, 16'h0013);
    send_restart();
    send_header(32'd20, 32'h0000_0014, 16'h0014);
    send_restart();
    // unmapped word: the maximum must stay at five
    wait_idle();
    apb_write(AddrUnused, 32'd100);
    send_header(32'd20, 32'h0000_0015, 16'h0015);
    send_restart();
  endtask

  // restart in mid-header and mid-payload, parser picks up cleanly after each
  task automatic test_restart();
    set_max_frame(32'd64);
    send_header(dfr_pkg::HdrLen + 32'd1, 32'h0000_0020, 16'h0020);
    send_payload(1);
    repeat (5) send_beat(8'($urandom_range(255)), 1'b0);
    send_beat(8'hFF, 1'b1);
    send_header(dfr_pkg::HdrLen + 32'd2, 32'h0000_0021, 16'h0021);
    send_payload(1);
    send_beat(8'h00, 1'b1);
    send_header(dfr_pkg::HdrLen + 32'd1, 32'h0000_0022, 16'h0022);
    send_payload(1);
  endtask

  // mostly well-formed messages with random content; the rest broken or noise
  task automatic run_random_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    logic [31:0] len;
    logic [31:0] cut;
    start = bytes_fed;
    while (bytes_fed - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_restart();
      end else if (pick >= 93) begin
        // header broken off partway
        repeat ($urandom_range(1, dfr_pkg::HdrBytes - 1))
          send_beat(8'($urandom_range(255)), 1'b0);
        send_restart();
      end else begin
        if (pick < 60) len = dfr_pkg::HdrLen + $urandom_range(0, 14);
        else if (pick < 70) len = dfr_pkg::HdrLen + $urandom_range(15, 60);
        else if (pick < 75) len = max_frame;
        else if (pick < 80) len = max_frame + 32'd1;
        else if (pick < 87) len = $urandom_range(0, dfr_pkg::HdrBytes - 1);
        else len = $urandom;
        send_header(len, $urandom, 16'($urandom_range(16'hFFFF)));
        if (error_sticky) begin
          repeat ($urandom_range(0, 4)) send_beat(8'($urandom_range(255)), 1'b0);
          send_restart();
        end else if (payload_left != 0) begin
          cut = (payload_left > PayloadCap) ? PayloadCap : payload_left;
          if (cut < payload_left || $urandom_range(9) == 0) begin
            send_payload($urandom_range(0, cut));
            send_restart();
          end else begin
            send_payload(cut);
          end
        end
      end
    end
  endtask

  task automatic test_random_streams(input int unsigned src_pct, input int unsigned snk_pct,
                                     input logic [31:0] max_a, input int unsigned n_a,
                                     input logic [31:0] max_b, input int unsigned n_b);
    wait_idle();
    src_idle_pct  = src_pct;
    sink_idle_pct = snk_pct;
    set_max_frame(max_a);
    run_random_traffic(n_a);
    set_max_frame(max_b);
    run_random_traffic(n_b);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_header_fields();
    test_length_errors();
    test_max_extremes();
    test_restart();
    // sender busy and receiver stalling, then the reverse, then full rate
    test_random_streams(9, 82, $urandom_range(dfr_pkg::HdrBytes, 40), 250, 32'hFFFF_FFFF, 150);
    test_random_streams(82, 9, dfr_pkg::HdrLen, 120, dfr_pkg::MaxFrameReset, 280);
    test_random_streams(0, 0, $urandom_range(0, dfr_pkg::HdrBytes - 1), 60,
                        $urandom_range(dfr_pkg::HdrBytes + 5, 60), 300);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 32'(pending_results.size()), 32'h0);

    $display("stream of %0d bytes and %0d restarts under three idling mixes and many maxima",
             bytes_fed, restarts);
    $display("delivered %0d headers, %0d payload beats, %0d short and %0d long framing errors",
             headers_seen, payloads_seen, short_errs, long_errs);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hang detector: any beat on in_ch, out_ch or the apb port resets the count
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_psel && cfg_penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no beat for %0d cycles", StallLimit);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
src/dfr_pkg.sv
src/dfr_if.sv
src/dfr_front.sv
src/dfr_queue.sv
src/dfr_back.sv
src/length_prefixed_deframer_core.sv
dv/tb_length_prefixed_deframer_core.sv
